// ===== rtl/tiqb_pkg.sv =====
package tiqb_pkg;

    localparam int NUM_SENSORS = 10;
    localparam int NUM_LIMITS  = 8;
    localparam int NUM_KEYS    = 4;
    localparam int NUM_AUTO    = 2;

    // Keys at this index and above are the right keys, which qualify on the
    // threshold tick itself.
    localparam int RIGHT_KEY_FIRST = 2;

    // Sensor slots behind the limit switches.
    localparam int EMERGENCY_IDX = 8;
    localparam int OVERLOAD_IDX  = 9;

    localparam int CNT_W = 8;
    localparam int CFG_W = 8;

    localparam logic [CFG_W-1:0] DEBOUNCE_TICKS_RST = 8'd20;
    localparam logic [CFG_W-1:0] KEY_DELAY_RST      = 8'd50;
    localparam logic [CFG_W-1:0] AUTO_DELAY_RST     = 8'd50;
    localparam logic [CFG_W-1:0] BEEP_TICKS_RST     = 8'd100;

    typedef enum logic [1:0] {
        CFG_DEBOUNCE_TICKS = 2'd0,
        CFG_KEY_DELAY      = 2'd1,
        CFG_AUTO_DELAY     = 2'd2,
        CFG_BEEP_TICKS     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             hit;
    } count_step_t;

    // One saturating count step. The increment is one bit wider so that a
    // counter already at its delay stays there, and a counter above a newly
    // lowered delay clamps to it.
    function automatic count_step_t count_up(input logic [CNT_W-1:0] cnt,
                                             input logic [CNT_W-1:0] delay);
        logic [CNT_W:0] n;
        count_step_t    r;
        n = {1'b0, cnt} + {{CNT_W{1'b0}}, 1'b1};
        if (n >= {1'b0, delay})
        begin
            r.cnt = delay;
            r.hit = 1'b1;
        end
        else
        begin
            r.cnt = n[CNT_W-1:0];
            r.hit = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== rtl/tick_input_qualifier_bank_top.sv =====
// Input qualifier for a limit-switch and key panel. Each input beat is one
// 1 ms tick carrying the raw levels of eight limit switches, the emergency
// and overload inputs, four keys and two auto inputs; each output beat is the
// qualified view after that tick. The ten sensor inputs use symmetric
// debouncers: separate on and off run counters saturate at the debounce
// delay (register 0) and only then does the qualified level follow. Keys and
// auto inputs use leaky up/down counters that saturate at key_delay or
// auto_delay and clear their flag only on a low tick that finds the counter
// empty. When a key counter first reaches key_delay, the beep countdown loads
// with beep_ticks; beep_on is high while that countdown is above one and
// beep_active while it is nonzero. The left keys set their flag one tick
// after the threshold and the right keys on the threshold tick itself. The
// block accepts one tick per clock cycle while in_stall is low and delivers
// its result in the next cycle: all counter updates for a tick are a single
// layer of saturating adds between the state registers and the output
// register. The output register holds a finished result while out_stall
// is high, and in_stall is raised only while that register is full and
// stalled. Configuration registers are written through cfg_we, cfg_index
// and cfg_data and should only be changed while idle.
module tick_input_qualifier_bank_top
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] raw_limits,
    input  logic       raw_emergency,
    input  logic       raw_overload,
    input  logic [3:0] raw_keys,
    input  logic [1:0] raw_auto,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] good_limits,
    output logic       good_emergency,
    output logic       good_overload,
    output logic [3:0] key_flags,
    output logic [1:0] auto_flags,
    output logic       beep_on,
    output logic       beep_active
);

    localparam int NS = tiqb_pkg::NUM_SENSORS;
    localparam int NK = tiqb_pkg::NUM_KEYS;
    localparam int NA = tiqb_pkg::NUM_AUTO;
    localparam int CW = tiqb_pkg::CNT_W;

    // Configuration registers.
    logic [CW-1:0] debounce_ticks_reg;
    logic [CW-1:0] key_delay_reg;
    logic [CW-1:0] auto_delay_reg;
    logic [CW-1:0] beep_ticks_reg;

    // Qualifier state.
    logic [CW-1:0] on_run_reg     [NS];
    logic [CW-1:0] off_run_reg    [NS];
    logic [NS-1:0] sensor_level_reg;
    logic [CW-1:0] key_count_reg  [NK];
    logic [NK-1:0] key_level_reg;
    logic [CW-1:0] auto_count_reg [NA];
    logic [NA-1:0] auto_level_reg;
    logic [CW-1:0] beep_left_reg;

    logic [CW-1:0] on_run_next     [NS];
    logic [CW-1:0] off_run_next    [NS];
    logic [NS-1:0] sensor_level_next;
    logic [CW-1:0] key_count_next  [NK];
    logic [NK-1:0] key_level_next;
    logic [CW-1:0] auto_count_next [NA];
    logic [NA-1:0] auto_level_next;
    logic [CW-1:0] beep_left_next;
    logic          beep_on_next;
    logic          beep_active_next;

    // Output register.
    logic          out_valid_reg;
    logic [NS-1:0] out_sensor_reg;
    logic [NK-1:0] out_keys_reg;
    logic [NA-1:0] out_auto_reg;
    logic          out_beep_on_reg;
    logic          out_beep_active_reg;

    logic          in_accept;
    logic [NS-1:0] raw_sensors;

    // The output register is free when empty or being drained this cycle.
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    assign raw_sensors = {raw_overload, raw_emergency, raw_limits};

    // Next state for one tick.
    always_comb
    begin
        tiqb_pkg::count_step_t step;
        logic [CW:0]           kn;
        logic                  beep_load;
        logic [CW-1:0]         beep_cur;

        beep_load = 1'b0;

        // Sensor debouncers: a tick at one level clears the other level's
        // run and counts its own.
        for (int i = 0; i < NS; i++)
        begin
            sensor_level_next[i] = sensor_level_reg[i];
            if (raw_sensors[i])
            begin
                step            = tiqb_pkg::count_up(on_run_reg[i], debounce_ticks_reg);
                on_run_next[i]  = step.cnt;
                off_run_next[i] = '0;
                if (step.hit)
                begin
                    sensor_level_next[i] = 1'b1;
                end
            end
            else
            begin
                step            = tiqb_pkg::count_up(off_run_reg[i], debounce_ticks_reg);
                off_run_next[i] = step.cnt;
                on_run_next[i]  = '0;
                if (step.hit)
                begin
                    sensor_level_next[i] = 1'b0;
                end
            end
        end

        // Key leaky counters. Reaching the threshold exactly loads the beep;
        // only the right keys qualify on that same tick.
        for (int k = 0; k < NK; k++)
        begin
            key_level_next[k] = key_level_reg[k];
            key_count_next[k] = key_count_reg[k];
            kn = {1'b0, key_count_reg[k]} + {{CW{1'b0}}, 1'b1};
            if (!raw_keys[k])
            begin
                if (key_count_reg[k] != '0)
                begin
                    key_count_next[k] = key_count_reg[k] - {{(CW-1){1'b0}}, 1'b1};
                end
                else
                begin
                    key_level_next[k] = 1'b0;
                end
            end
            else if (kn == {1'b0, key_delay_reg})
            begin
                beep_load         = 1'b1;
                key_count_next[k] = key_delay_reg;
                if (k >= tiqb_pkg::RIGHT_KEY_FIRST)
                begin
                    key_level_next[k] = 1'b1;
                end
            end
            else if (kn > {1'b0, key_delay_reg})
            begin
                key_count_next[k] = key_delay_reg;
                key_level_next[k] = 1'b1;
            end
            else
            begin
                key_count_next[k] = kn[CW-1:0];
            end
        end

        // Beep countdown is sampled after any load, then decremented.
        beep_cur         = beep_load ? beep_ticks_reg : beep_left_reg;
        beep_active_next = (beep_cur != '0);
        beep_on_next     = (beep_cur > {{(CW-1){1'b0}}, 1'b1});
        beep_left_next   = beep_cur - {{(CW-1){1'b0}}, beep_active_next};

        // Auto input leaky counters.
        for (int a = 0; a < NA; a++)
        begin
            auto_level_next[a] = auto_level_reg[a];
            if (raw_auto[a])
            begin
                step               = tiqb_pkg::count_up(auto_count_reg[a], auto_delay_reg);
                auto_count_next[a] = step.cnt;
                if (step.hit)
                begin
                    auto_level_next[a] = 1'b1;
                end
            end
            else
            begin
                auto_count_next[a] = auto_count_reg[a];
                if (auto_count_reg[a] != '0)
                begin
                    auto_count_next[a] = auto_count_reg[a] - {{(CW-1){1'b0}}, 1'b1};
                end
                else
                begin
                    auto_level_next[a] = 1'b0;
                end
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg <= tiqb_pkg::DEBOUNCE_TICKS_RST;
            key_delay_reg      <= tiqb_pkg::KEY_DELAY_RST;
            auto_delay_reg     <= tiqb_pkg::AUTO_DELAY_RST;
            beep_ticks_reg     <= tiqb_pkg::BEEP_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (tiqb_pkg::cfg_index_t'(cfg_index))
                tiqb_pkg::CFG_DEBOUNCE_TICKS: debounce_ticks_reg <= cfg_data;
                tiqb_pkg::CFG_KEY_DELAY:      key_delay_reg      <= cfg_data;
                tiqb_pkg::CFG_AUTO_DELAY:     auto_delay_reg     <= cfg_data;
                tiqb_pkg::CFG_BEEP_TICKS:     beep_ticks_reg     <= cfg_data;
            endcase
        end
    end

    // Qualifier state advances once per accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                on_run_reg[i]  <= '0;
                off_run_reg[i] <= '0;
            end
            for (int k = 0; k < NK; k++)
            begin
                key_count_reg[k] <= '0;
            end
            for (int a = 0; a < NA; a++)
            begin
                auto_count_reg[a] <= '0;
            end
            sensor_level_reg <= '0;
            key_level_reg    <= '0;
            auto_level_reg   <= '0;
            beep_left_reg    <= '0;
        end
        else if (in_accept)
        begin
            on_run_reg       <= on_run_next;
            off_run_reg      <= off_run_next;
            key_count_reg    <= key_count_next;
            auto_count_reg   <= auto_count_next;
            sensor_level_reg <= sensor_level_next;
            key_level_reg    <= key_level_next;
            auto_level_reg   <= auto_level_next;
            beep_left_reg    <= beep_left_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload, loaded only with a new tick so a stalled beat holds.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_sensor_reg      <= sensor_level_next;
            out_keys_reg        <= key_level_next;
            out_auto_reg        <= auto_level_next;
            out_beep_on_reg     <= beep_on_next;
            out_beep_active_reg <= beep_active_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign good_limits    = out_sensor_reg[tiqb_pkg::NUM_LIMITS-1:0];
    assign good_emergency = out_sensor_reg[tiqb_pkg::EMERGENCY_IDX];
    assign good_overload  = out_sensor_reg[tiqb_pkg::OVERLOAD_IDX];
    assign key_flags      = out_keys_reg;
    assign auto_flags     = out_auto_reg;
    assign beep_on        = out_beep_on_reg;
    assign beep_active    = out_beep_active_reg;

    // An accepted tick always shows up as a result on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid)
        else $error("accepted tick produced no result beat");

    // A sensor never has both its on run and its off run counting.
    for (genvar g = 0; g < NS; g++)
    begin : g_run_chk
        assert property (@(posedge clk) disable iff (!rst_n)
            !((on_run_reg[g] != '0) && (off_run_reg[g] != '0)))
            else $error("sensor on and off runs both nonzero");
    end

    // The buzzer is only driven while the beep countdown is running.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && beep_on) |-> beep_active)
        else $error("beep_on without beep_active");

    // A held beat is not overwritten while the consumer stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> !$past(in_accept))
        else $error("tick accepted into a stalled output register");

endmodule
